@@ hw/rtl/internet_checksum_pseudo_header_top_defines.svh @@
// ============================================================================
// internet_checksum_pseudo_header_top_defines.svh
// Assertion macros shared by the checksum block.
// ============================================================================
`ifndef INTERNET_CHECKSUM_PSEUDO_HEADER_TOP_DEFINES_SVH
`define INTERNET_CHECKSUM_PSEUDO_HEADER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ICPH_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("icph: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ICPH_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("icph: next-cycle check failed");

`endif

@@ hw/rtl/icph_pkg.sv @@
// ============================================================================
// icph_pkg
// Types and constants of the internet checksum block.
// ============================================================================
`default_nettype none

package icph_pkg;

    localparam int WordW  = 16;
    localparam int ProtoW = 8;
    localparam int AddrW  = 32;

    // stream payload widths
    localparam int STDataW = WordW + ProtoW + 2 * AddrW;   // 88 bits, whole bytes
    localparam int MTDataW = WordW;

    // job queue between accumulator and finisher; depth is a power of two
    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    // seven 16-bit terms summed before folding
    localparam int NumTerms = 7;
    localparam int RawW     = WordW + $clog2(NumTerms);

    localparam logic [WordW-1:0] HighByteMask = 16'hFF00;

    // one finished packet waiting for the pseudo-header and fold
    typedef struct packed {
        logic [WordW-1:0]  sum;
        logic [WordW-1:0]  byte_count;
        logic [ProtoW-1:0] protocol;
        logic [AddrW-1:0]  source_address;
        logic [AddrW-1:0]  dest_address;
    } job_t;

    typedef struct packed {
        logic             full;
        logic             empty;
        logic [QCntW-1:0] count;
    } queue_status_t;

    // 16-bit ones-complement add with end-around carry
    function automatic logic [WordW-1:0] oc_add(input logic [WordW-1:0] a,
                                                input logic [WordW-1:0] b);
        logic [WordW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WordW-1:0] + {{(WordW-1){1'b0}}, s[WordW]};
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/icph_front.sv @@
// ============================================================================
// icph_front
// Accumulates packet words and byte count; hands finished packets to the queue.
// ============================================================================
`default_nettype none

module icph_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           accept,
    input  wire logic [icph_pkg::WordW-1:0]     data_word,
    input  wire logic                           single_byte,
    input  wire logic                           last,
    input  wire logic [icph_pkg::ProtoW-1:0]    protocol,
    input  wire logic [icph_pkg::AddrW-1:0]     source_address,
    input  wire logic [icph_pkg::AddrW-1:0]     dest_address,
    output logic                                push,
    output icph_pkg::job_t                      job,
    output logic                                acc_clear
);

    logic [icph_pkg::WordW-1:0] sum_reg, sum_next;
    logic [icph_pkg::WordW-1:0] count_reg, count_next;
    logic [icph_pkg::WordW-1:0] word;
    logic [icph_pkg::WordW-1:0] sum_upd;
    logic [icph_pkg::WordW-1:0] count_upd;

    always_comb begin
        // a lone final byte is the high byte, low byte zero
        if (last && single_byte) begin
            word      = data_word & icph_pkg::HighByteMask;
            count_upd = count_reg + icph_pkg::WordW'(1);
        end else begin
            word      = data_word;
            count_upd = count_reg + icph_pkg::WordW'(2);
        end
        sum_upd = icph_pkg::oc_add(sum_reg, word);

        sum_next   = sum_reg;
        count_next = count_reg;
        if (accept) begin
            sum_next   = last ? '0 : sum_upd;
            count_next = last ? '0 : count_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            count_reg <= '0;
        end else begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    assign push                = accept && last;
    assign job.sum             = sum_upd;
    assign job.byte_count      = count_upd;
    assign job.protocol        = protocol;
    assign job.source_address  = source_address;
    assign job.dest_address    = dest_address;
    assign acc_clear           = (sum_reg == '0) && (count_reg == '0);

endmodule

`default_nettype wire

@@ hw/rtl/icph_queue.sv @@
// ============================================================================
// icph_queue
// Small FIFO of finished packet jobs.
// ============================================================================
`default_nettype none

module icph_queue (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   push,
    input  wire icph_pkg::job_t         push_job,
    input  wire logic                   pop,
    output icph_pkg::job_t              head_job,
    output icph_pkg::queue_status_t     status
);

    icph_pkg::job_t mem [icph_pkg::QDepth];

    logic [icph_pkg::QPtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [icph_pkg::QPtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [icph_pkg::QCntW-1:0] count_reg, count_next;
    logic                       do_push;
    logic                       do_pop;

    assign status.full  = (count_reg == icph_pkg::QCntW'(icph_pkg::QDepth));
    assign status.empty = (count_reg == '0);
    assign status.count = count_reg;

    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;

    always_comb begin
        // pointers wrap naturally: depth is a power of two
        wr_ptr_next = do_push ? wr_ptr_reg + icph_pkg::QPtrW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + icph_pkg::QPtrW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + icph_pkg::QCntW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - icph_pkg::QCntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head_job = mem[rd_ptr_reg];

endmodule

`default_nettype wire

@@ hw/rtl/icph_back.sv @@
// ============================================================================
// icph_back
// Adds the pseudo-header, folds carries, inverts and drives the result.
// ============================================================================
`default_nettype none

module icph_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           head_valid,
    input  wire icph_pkg::job_t                 head_job,
    output logic                                pop,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [icph_pkg::MTDataW-1:0]        m_tdata
);

    localparam int RawW  = icph_pkg::RawW;
    localparam int WordW = icph_pkg::WordW;

    logic                   s1_valid_reg, s1_valid_next;
    logic [RawW-1:0]        s1_raw_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [WordW-1:0]       out_data_reg;

    logic                   out_load;
    logic                   s1_load;
    logic                   use_ph;
    logic [RawW-1:0]        raw;
    logic [WordW:0]         fold1;
    logic [WordW-1:0]       fold2;

    // stage 1: wide sum of packet sum and pseudo-header terms
    always_comb begin
        use_ph = (head_job.protocol != '0);
        raw = RawW'(head_job.sum) + RawW'(head_job.protocol);
        if (use_ph) begin
            raw = raw
                + RawW'(head_job.source_address[31:16])
                + RawW'(head_job.source_address[15:0])
                + RawW'(head_job.dest_address[31:16])
                + RawW'(head_job.dest_address[15:0])
                + RawW'(head_job.byte_count);
        end
    end

    // stage 2: two end-around folds bring the total to 16 bits
    always_comb begin
        fold1 = (WordW+1)'(s1_raw_reg[WordW-1:0])
              + (WordW+1)'(s1_raw_reg[RawW-1:WordW]);
        fold2 = fold1[WordW-1:0] + WordW'(fold1[WordW]);
    end

    assign out_load = !out_valid_reg || m_tready;
    assign s1_load  = !s1_valid_reg || out_load;
    assign pop      = s1_load && head_valid;

    always_comb begin
        s1_valid_next  = s1_load  ? head_valid   : s1_valid_reg;
        out_valid_next = out_load ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (s1_load) begin
            s1_raw_reg <= raw;
        end
        if (out_load) begin
            out_data_reg <= ~fold2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/internet_checksum_pseudo_header_top.sv @@
// ============================================================================
// internet_checksum_pseudo_header_top
// RFC 1071 internet checksum over a word stream, with IPv4 pseudo-header.
// ============================================================================
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-----------------------------------
//  s_      | in  | s_tvalid / s_tready  | s_tdata, s_tuser, s_tlast
//  m_      | out | m_tvalid / m_tready  | m_tdata (one item per packet)
//
//  One input item per clock while the job queue has room. The accumulator folds
//  each word into the running sum in the cycle it is accepted; after the last
//  item the checksum passes queue write, wide pseudo-header add and fold.
//  Reset (aresetn low, synchronous) clears sums, counts, queue and valids.
//  A stalled m_ side backs up the output stage, the add stage and a four-entry
//  job queue; s_tready drops only when that queue is full.
//
`default_nettype none

`include "internet_checksum_pseudo_header_top_defines.svh"

module internet_checksum_pseudo_header_top (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // s_tdata, from bit 0: data_word[15:0], protocol[23:16],
    //                      source_address[55:24], dest_address[87:56]
    input  wire logic [icph_pkg::STDataW-1:0]   s_tdata,
    // s_tuser: single_byte
    input  wire logic                           s_tuser,
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // m_tdata, from bit 0: checksum[15:0]
    output logic [icph_pkg::MTDataW-1:0]        m_tdata
);

    logic                       s_accept;
    logic                       push;
    logic                       pop;
    logic                       acc_clear;
    icph_pkg::job_t             push_job;
    icph_pkg::job_t             head_job;
    icph_pkg::queue_status_t    q_status;

    // the front can always take a word; only the job queue can push back
    assign s_tready = !q_status.full;
    assign s_accept = s_tvalid && s_tready;

    icph_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (s_accept),
        .data_word      (s_tdata[15:0]),
        .single_byte    (s_tuser),
        .last           (s_tlast),
        .protocol       (s_tdata[23:16]),
        .source_address (s_tdata[55:24]),
        .dest_address   (s_tdata[87:56]),
        .push           (push),
        .job            (push_job),
        .acc_clear      (acc_clear)
    );

    icph_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    icph_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (!q_status.empty),
        .head_job   (head_job),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // ---- assertions ---------------------------------------------------------

    // a packet end leaves the accumulator cleared for the next packet
    `ICPH_ASSERT_NEXT(a_acc_cleared, aclk, aresetn, s_accept && s_tlast, acc_clear)

    // a packet end always lands in the queue
    `ICPH_ASSERT_NEXT(a_job_queued, aclk, aresetn, s_accept && s_tlast && !pop,
                      q_status.count == $past(q_status.count) + icph_pkg::QCntW'(1))

    // the back end never pops an empty queue
    `ICPH_ASSERT_NOW(a_no_empty_pop, aclk, aresetn, pop, !q_status.empty)

    // input stalls only when the queue is really full
    `ICPH_ASSERT_NOW(a_stall_full, aclk, aresetn, !s_tready,
                     q_status.count == icph_pkg::QCntW'(icph_pkg::QDepth))

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// ============================================================================
// tb
// Checks the internet checksum block with a pseudo-header, over random
// packets.
// Packet words are driven on the s_ stream and the checksums are collected on
// the m_ stream. Both sides stall at random. A scoreboard sums each accepted
// word the same way the block should and queues one checksum per packet. Each
// result is compared with the oldest queued checksum.
// ============================================================================

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------------
    // Scoreboard: running ones-complement sum, byte count, queued checksums
    // ------------------------------------------------------------------------
    class checksum_scoreboard;
        logic [icph_pkg::WordW-1:0] word_sum;
        logic [icph_pkg::WordW-1:0] byte_total;
        logic [icph_pkg::WordW-1:0] due_checksums[$];
        int                         errors;

        function new();
            word_sum   = '0;
            byte_total = '0;
            errors     = 0;
        endfunction

        // end-around-carry add, folded from a 32-bit sum
        function logic [icph_pkg::WordW-1:0] fold_add(logic [icph_pkg::WordW-1:0] a,
                                                      logic [icph_pkg::WordW-1:0] b);
            int unsigned t;
            t = int'(a) + int'(b);
            t = (t & 32'h0000_FFFF) + (t >> 16);
            return t[icph_pkg::WordW-1:0];
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        // one accepted input item
        function void note_item(logic [icph_pkg::WordW-1:0] w, bit one_byte, bit lst,
                                logic [icph_pkg::ProtoW-1:0] proto,
                                logic [icph_pkg::AddrW-1:0] src,
                                logic [icph_pkg::AddrW-1:0] dst);
            logic [icph_pkg::WordW-1:0] total;
            if (lst && one_byte) begin
                w          = w & icph_pkg::HighByteMask;
                byte_total = byte_total + 16'd1;
            end else begin
                byte_total = byte_total + 16'd2;
            end
            word_sum = fold_add(word_sum, w);
            if (lst) begin
                total = word_sum;
                if (proto != '0) begin
                    total = fold_add(total, src[31:16]);
                    total = fold_add(total, src[15:0]);
                    total = fold_add(total, dst[31:16]);
                    total = fold_add(total, dst[15:0]);
                    total = fold_add(total, {8'h00, proto});
                    total = fold_add(total, byte_total);
                end
                due_checksums.push_back(~total);
                word_sum   = '0;
                byte_total = '0;
            end
        endfunction

        // one accepted result item
        task check_result(logic [icph_pkg::WordW-1:0] got);
            logic [icph_pkg::WordW-1:0] want;
            if (due_checksums.size() == 0) begin
                report($sformatf("checksum %h with no packet pending", got));
            end else begin
                want = due_checksums.pop_front();
                if (got !== want)
                    report($sformatf("checksum %h, expected %h", got, want));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, block
    // ------------------------------------------------------------------------
    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [icph_pkg::STDataW-1:0]   s_tdata  = '0;
    logic                           s_tuser  = 1'b0;
    logic                           s_tlast  = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [icph_pkg::MTDataW-1:0]   m_tdata;

    // set while stalls are switched off on both sides
    bit quiet = 1'b0;
    int sent  = 0;

    checksum_scoreboard sb = new();

    always #10 aclk = ~aclk;

    internet_checksum_pseudo_header_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // receiver: stalls about a quarter of the cycles unless quiet
    always @(negedge aclk) begin
        m_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 24);
    end

    // result items are checked at the edge that accepts them
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // ------------------------------------------------------------------------
    // Sender. Called just after a rising edge; returns at the accepting edge.
    // ------------------------------------------------------------------------
    task automatic send_item(logic [icph_pkg::WordW-1:0] w, bit one_byte, bit lst,
                             logic [icph_pkg::ProtoW-1:0] proto,
                             logic [icph_pkg::AddrW-1:0] src,
                             logic [icph_pkg::AddrW-1:0] dst);
        @(negedge aclk);
        while (!quiet && $urandom_range(0, 99) < 24) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {dst, src, proto, w};
        s_tuser  <= one_byte;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        sb.note_item(w, one_byte, lst, proto, src, dst);
        sent++;
    endtask

    // word with a bias toward the carry-heavy extremes
    function automatic logic [icph_pkg::WordW-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            default: return icph_pkg::WordW'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    function automatic logic [icph_pkg::ProtoW-1:0] pick_proto();
        case ($urandom_range(0, 9)) inside
            [0:2]: return 8'h00;     // no pseudo-header
            3: return 8'hFF;
            default: return icph_pkg::ProtoW'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [icph_pkg::AddrW-1:0] pick_addr();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    // a packet of n words; non-last items carry junk in the ignored fields
    task automatic send_packet(int n);
        for (int i = 0; i < n - 1; i++)
            send_item(pick_word(), 1'($urandom_range(0, 1)), 1'b0,
                      icph_pkg::ProtoW'($urandom_range(0, 255)), $urandom(), $urandom());
        send_item(pick_word(), $urandom_range(0, 2) == 0, 1'b1, pick_proto(),
                  pick_addr(), pick_addr());
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int waited;
        int len;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed: one-word packets at the extremes ---
        send_item(16'h0000, 1'b0, 1'b1, 8'h00, 32'h0000_0000, 32'h0000_0000);
        send_item(16'hFFFF, 1'b0, 1'b1, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // last item with only the high byte; the low half must be dropped
        send_item(16'hFFFF, 1'b1, 1'b1, 8'h00, 32'h0000_0000, 32'h0000_0000);
        send_item(16'h12FF, 1'b1, 1'b1, 8'h11, 32'hC0A8_0001, 32'h0A00_0002);
        // pseudo-header everywhere at all ones: heavy end-around carry
        send_item(16'hFFFF, 1'b0, 1'b1, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(16'h0000, 1'b0, 1'b1, 8'h01, 32'h0000_0000, 32'h0000_0000);
        send_item(16'h8000, 1'b0, 1'b1, 8'h80, 32'h8000_8000, 32'h8000_0000);
        // single-byte flag and pseudo-header fields on non-last items are ignored
        send_item(16'hABCD, 1'b1, 1'b0, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(16'h1234, 1'b0, 1'b1, 8'h06, 32'h0102_0304, 32'h0506_0708);
        // carries across several words
        send_item(16'hFFFF, 1'b0, 1'b0, 8'h00, 32'h0000_0000, 32'h0000_0000);
        send_item(16'hFFFF, 1'b0, 1'b0, 8'h00, 32'h0000_0000, 32'h0000_0000);
        send_item(16'h0001, 1'b0, 1'b1, 8'h11, 32'hFFFF_0000, 32'h0000_FFFF);
        // odd byte count with pseudo-header
        send_item(16'h8000, 1'b0, 1'b0, 8'h00, 32'h0000_0000, 32'h0000_0000);
        send_item(16'h8000, 1'b0, 1'b0, 8'h00, 32'h0000_0000, 32'h0000_0000);
        send_item(16'h80AA, 1'b1, 1'b1, 8'h06, 32'h7FFF_FFFF, 32'hFFFF_FFFE);
        // protocol zero with nonzero addresses: no pseudo-header
        send_item(16'h4321, 1'b0, 1'b0, 8'h00, 32'h0000_0000, 32'h0000_0000);
        send_item(16'h5A5A, 1'b0, 1'b1, 8'h00, 32'hDEAD_BEEF, 32'hA5A5_5A5A);

        // --- random packets, mostly short ---
        while (sent < 2000) begin
            quiet = (sent >= 900 && sent < 1300);
            if ($urandom_range(0, 19) == 0)
                len = $urandom_range(13, 80);
            else
                len = $urandom_range(1, 12);
            send_packet(len);
        end
        quiet = 1'b0;

        send_packet(2);

        @(negedge aclk);
        s_tvalid <= 1'b0;

        // drain: queue and pipeline stages plus receiver stalls
        waited = 0;
        while (sb.due_checksums.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (10) @(posedge aclk);
        if (sb.due_checksums.size() != 0)
            sb.report($sformatf("%0d checksums never arrived", sb.due_checksums.size()));

        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog, well past the slowest legal run
    initial begin
        #40ms;
        $display("FAIL");
        $finish;
    end

endmodule

@@ internet_checksum_pseudo_header_top.f @@
+incdir+hw/rtl
hw/rtl/icph_pkg.sv
hw/rtl/icph_front.sv
hw/rtl/icph_queue.sv
hw/rtl/icph_back.sv
hw/rtl/internet_checksum_pseudo_header_top.sv
sim/tb.sv
